/* hw/rtl/fats_pkg.sv */
// ----------------------------------------------------------------------------
// fats_pkg - flap actuator test sequencer definitions
// Phase codes, register indexes, limits and the status flag record.
// ----------------------------------------------------------------------------
package fats_pkg;

    // Sequencer phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_OPEN  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;
    localparam logic [1:0] PH_END   = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_OPEN_DELAY  = 2'd0;
    localparam logic [1:0] REG_CLOSE_DELAY = 2'd1;
    localparam logic [1:0] REG_END_HOLD    = 2'd2;
    localparam logic [1:0] REG_TEST_CODE   = 2'd3;

    // Register reset values
    localparam logic [7:0] OPEN_DELAY_RST  = 8'd100;
    localparam logic [7:0] CLOSE_DELAY_RST = 8'd50;
    localparam logic [7:0] END_HOLD_RST    = 8'd50;
    localparam logic [7:0] TEST_CODE_RST   = 8'd0;

    // Countdown limits applied at load time
    localparam logic [7:0] OPEN_MAX  = 8'd100;
    localparam logic [7:0] CLOSE_MAX = 8'd50;
    localparam logic [7:0] HOLD_MAX  = 8'd50;

    // Position command values
    localparam logic [7:0] CMD_MAX   = 8'd3;
    localparam logic [1:0] CMD_OPEN  = 2'd3;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Measured flap positions
    localparam logic [7:0] POS_OPEN_A  = 8'd0;
    localparam logic [7:0] POS_CLOSED  = 8'd1;
    localparam logic [7:0] POS_BLOCKED = 8'd2;
    localparam logic [7:0] POS_OPEN_B  = 8'd3;

    typedef struct packed {
        logic in_progress;
        logic active;
        logic complete;
        logic blocked_open;
        logic flap_failed;
        logic stays_open;
    } flags_t;

endpackage

/* hw/rtl/flap_actuator_test_sequencer.sv */
// ----------------------------------------------------------------------------
// flap_actuator_test_sequencer - service-tool flap actuator test
// Walks idle, opening, closing and end phases on periodic ticks, latches
// verdicts on the measured flap position and drives the position command.
// ----------------------------------------------------------------------------
// One tick is one input transaction. The block takes a tick in every cycle
// unless in_stall is raised, and returns one result per tick: the tick is
// captured in an input register at the accepting edge, the phase logic works
// on the input register and its outcome is loaded into the result register,
// which is also the sequencer state, when that register is empty or being
// taken. Throughput is one tick per clock while neither side is stalled; a
// stall on the result side backs up into the input register before the input
// side is stalled. The user must write the registers through the APB port
// only while no tick is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module flap_actuator_test_sequencer (
    input  logic        clk,
    input  logic        rst_n,

    // tick channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        service_enable,
    input  logic [7:0]  action_code,
    input  logic [7:0]  flap_position,
    input  logic [7:0]  position_request,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  test_phase,
    output logic        test_in_progress,
    output logic        actuator_active,
    output logic        test_complete,
    output logic        blocked_open,
    output logic        flap_failed,
    output logic        stays_open,
    output logic [1:0]  position_command,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fats_pkg::*;

    // Configuration registers
    logic [7:0] open_delay_reg;
    logic [7:0] close_delay_reg;
    logic [7:0] end_hold_reg;
    logic [7:0] test_code_reg;

    // Input stage
    logic       s1_valid_reg;
    logic       s1_enable_reg;
    logic [7:0] s1_code_reg;
    logic [7:0] s1_pos_reg;
    logic [7:0] s1_req_reg;

    // Sequencer state, doubles as the result register
    logic       out_valid_reg;
    logic [1:0] phase_reg,       phase_next;
    logic [6:0] open_timer_reg,  open_timer_next;
    logic [5:0] close_timer_reg, close_timer_next;
    logic [5:0] hold_timer_reg,  hold_timer_next;
    flags_t     flags_reg,       flags_next;
    logic [1:0] command_reg,     command_next;

    logic       cfg_write;
    logic       advance;
    logic       en;
    logic [1:0] req_clamp;
    logic [6:0] open_load;
    logic [5:0] close_load;
    logic [5:0] hold_load;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_delay_reg  <= OPEN_DELAY_RST;
            close_delay_reg <= CLOSE_DELAY_RST;
            end_hold_reg    <= END_HOLD_RST;
            test_code_reg   <= TEST_CODE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_OPEN_DELAY:  open_delay_reg  <= pwdata[7:0];
                REG_CLOSE_DELAY: close_delay_reg <= pwdata[7:0];
                REG_END_HOLD:    end_hold_reg    <= pwdata[7:0];
                REG_TEST_CODE:   test_code_reg   <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OPEN_DELAY:  prdata = {24'd0, open_delay_reg};
            REG_CLOSE_DELAY: prdata = {24'd0, close_delay_reg};
            REG_END_HOLD:    prdata = {24'd0, end_hold_reg};
            REG_TEST_CODE:   prdata = {24'd0, test_code_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ----------------------------------------------------------- handshakes
    // Advance the input stage into the result register whenever the result
    // register is empty or being taken; stall input only when both are full.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the tick payload; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_enable_reg <= service_enable;
            s1_code_reg   <= action_code;
            s1_pos_reg    <= flap_position;
            s1_req_reg    <= position_request;
        end
    end

    // ----------------------------------------------------------- phase logic
    assign en        = s1_enable_reg && (s1_code_reg == test_code_reg);
    assign req_clamp = (s1_req_reg > CMD_MAX) ? CMD_MAX[1:0] : s1_req_reg[1:0];
    assign open_load = (open_delay_reg > OPEN_MAX) ? OPEN_MAX[6:0]
                                                   : open_delay_reg[6:0];
    assign close_load = (close_delay_reg > CLOSE_MAX) ? CLOSE_MAX[5:0]
                                                      : close_delay_reg[5:0];
    assign hold_load  = (end_hold_reg > HOLD_MAX) ? HOLD_MAX[5:0]
                                                  : end_hold_reg[5:0];

    always_comb
    begin
        phase_next       = phase_reg;
        open_timer_next  = open_timer_reg;
        close_timer_next = close_timer_reg;
        hold_timer_next  = hold_timer_reg;
        flags_next       = flags_reg;
        command_next     = command_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (en)
                begin
                    // Start a test: clear old verdicts, keep the completion flag
                    flags_next.in_progress  = 1'b1;
                    flags_next.active       = 1'b1;
                    flags_next.blocked_open = 1'b0;
                    flags_next.flap_failed  = 1'b0;
                    flags_next.stays_open   = 1'b0;
                    phase_next              = PH_OPEN;
                    command_next            = CMD_OPEN;
                    open_timer_next         = open_load;
                end
                else
                begin
                    command_next = req_clamp;
                end
            end
            PH_OPEN:
            begin
                if (!en)
                begin
                    phase_next             = PH_IDLE;
                    flags_next.in_progress = 1'b0;
                    flags_next.active      = 1'b0;
                    flags_next.complete    = 1'b0;
                    command_next           = req_clamp;
                end
                else if (s1_pos_reg == POS_CLOSED)
                begin
                    phase_next       = PH_CLOSE;
                    command_next     = CMD_CLOSE;
                    close_timer_next = close_load;
                end
                else if (open_timer_reg <= 7'd1)
                begin
                    // Timeout: only known not-closed positions end the test
                    if (s1_pos_reg == POS_OPEN_A || s1_pos_reg == POS_BLOCKED ||
                        s1_pos_reg == POS_OPEN_B)
                    begin
                        hold_timer_next     = hold_load;
                        phase_next          = PH_END;
                        flags_next.complete = 1'b1;
                        flags_next.active   = 1'b0;
                        command_next        = req_clamp;
                        if (s1_pos_reg == POS_BLOCKED)
                        begin
                            flags_next.blocked_open = 1'b1;
                        end
                        else
                        begin
                            flags_next.flap_failed = 1'b1;
                        end
                    end
                end
                else
                begin
                    open_timer_next = open_timer_reg - 7'd1;
                end
            end
            PH_CLOSE:
            begin
                if (!en)
                begin
                    phase_next             = PH_IDLE;
                    flags_next.in_progress = 1'b0;
                    flags_next.active      = 1'b0;
                    flags_next.complete    = 1'b0;
                    command_next           = req_clamp;
                end
                else if (close_timer_reg <= 6'd1)
                begin
                    if (s1_pos_reg != POS_OPEN_A)
                    begin
                        flags_next.stays_open = 1'b1;
                    end
                    hold_timer_next     = hold_load;
                    phase_next          = PH_END;
                    flags_next.complete = 1'b1;
                    flags_next.active   = 1'b0;
                    command_next        = req_clamp;
                end
                else
                begin
                    close_timer_next = close_timer_reg - 6'd1;
                end
            end
            PH_END:
            begin
                // Re-arm only once the hold has run out and the test is enabled
                if (en && hold_timer_reg == 6'd0)
                begin
                    phase_next             = PH_IDLE;
                    flags_next.in_progress = 1'b0;
                    flags_next.active      = 1'b0;
                    flags_next.complete    = 1'b0;
                    command_next           = req_clamp;
                end
                else
                begin
                    if (hold_timer_reg != 6'd0)
                    begin
                        hold_timer_next = hold_timer_reg - 6'd1;
                    end
                    command_next = req_clamp;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Update state only when a tick moves into the result register, so the
    // state always matches the result on display.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            open_timer_reg  <= '0;
            close_timer_reg <= '0;
            hold_timer_reg  <= '0;
            flags_reg       <= '0;
            command_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            open_timer_reg  <= open_timer_next;
            close_timer_reg <= close_timer_next;
            hold_timer_reg  <= hold_timer_next;
            flags_reg       <= flags_next;
            command_reg     <= command_next;
        end
    end

    // ---------------------------------------------------------------- result
    assign out_valid        = out_valid_reg;
    assign test_phase       = phase_reg;
    assign test_in_progress = flags_reg.in_progress;
    assign actuator_active  = flags_reg.active;
    assign test_complete    = flags_reg.complete;
    assign blocked_open     = flags_reg.blocked_open;
    assign flap_failed      = flags_reg.flap_failed;
    assign stays_open       = flags_reg.stays_open;
    assign position_command = command_reg;

endmodule

/* dv/flap_sequencer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flap_sequencer_checker - result predictor and scoreboard
// Tracks register writes and accepted ticks, predicts the sequencer result
// of every tick and compares it with the block's results in order.
// ----------------------------------------------------------------------------
module flap_sequencer_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        service_enable,
    input  logic [7:0]  action_code,
    input  logic [7:0]  flap_position,
    input  logic [7:0]  position_request,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  test_phase,
    input  logic        test_in_progress,
    input  logic        actuator_active,
    input  logic        test_complete,
    input  logic        blocked_open,
    input  logic        flap_failed,
    input  logic        stays_open,
    input  logic [1:0]  position_command,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          fail_count,
    output int          outstanding,
    output int          results_checked
);
    import fats_pkg::*;

    typedef struct packed {
        logic [1:0] phase;
        flags_t     flags;
        logic [1:0] command;
    } seq_result_t;

    logic [7:0]  cfg_open;
    logic [7:0]  cfg_close;
    logic [7:0]  cfg_hold;
    logic [7:0]  cfg_code;

    logic [1:0]  seq_phase;
    logic [7:0]  open_count;
    logic [7:0]  close_count;
    logic [7:0]  hold_count;
    flags_t      seq_flags;
    logic [1:0]  seq_cmd;

    seq_result_t expected_results[$];

    function automatic logic [7:0] limit_to(input logic [7:0] v, input logic [7:0] lim);
        return (v < lim) ? v : lim;
    endfunction

    task automatic enter_idle(input logic [1:0] req_cmd);
        seq_phase = PH_IDLE;
        seq_flags.in_progress = 1'b0;
        seq_flags.active = 1'b0;
        seq_flags.complete = 1'b0;
        seq_cmd = req_cmd;
    endtask

    task automatic enter_end(input logic [1:0] req_cmd);
        hold_count = limit_to(cfg_hold, HOLD_MAX);
        seq_phase = PH_END;
        seq_flags.complete = 1'b1;
        seq_flags.active = 1'b0;
        seq_cmd = req_cmd;
    endtask

    // Advance the sequencer by one tick.
    task automatic advance_sequencer(input logic svc, input logic [7:0] code,
                                     input logic [7:0] pos, input logic [7:0] req);
        logic       run;
        logic [7:0] req_limited;
        logic [1:0] req_cmd;
        run = svc && (code == cfg_code);
        req_limited = limit_to(req, CMD_MAX);
        req_cmd = req_limited[1:0];
        case (seq_phase)
            PH_IDLE:
            begin
                if (run)
                begin
                    seq_flags.in_progress = 1'b1;
                    seq_flags.active = 1'b1;
                    seq_flags.blocked_open = 1'b0;
                    seq_flags.flap_failed = 1'b0;
                    seq_flags.stays_open = 1'b0;
                    seq_phase = PH_OPEN;
                    seq_cmd = CMD_OPEN;
                    open_count = limit_to(cfg_open, OPEN_MAX);
                end
                else
                begin
                    seq_cmd = req_cmd;
                end
            end
            PH_OPEN:
            begin
                if (!run)
                begin
                    enter_idle(req_cmd);
                end
                else if (pos == POS_CLOSED)
                begin
                    seq_phase = PH_CLOSE;
                    seq_cmd = CMD_CLOSE;
                    close_count = limit_to(cfg_close, CLOSE_MAX);
                end
                else if (open_count <= 8'd1)
                begin
                    // unknown positions keep the sequencer waiting here
                    if (pos == POS_OPEN_A || pos == POS_BLOCKED || pos == POS_OPEN_B)
                    begin
                        enter_end(req_cmd);
                        if (pos == POS_BLOCKED)
                            seq_flags.blocked_open = 1'b1;
                        else
                            seq_flags.flap_failed = 1'b1;
                    end
                end
                else
                begin
                    open_count = open_count - 8'd1;
                end
            end
            PH_CLOSE:
            begin
                if (!run)
                begin
                    enter_idle(req_cmd);
                end
                else if (close_count <= 8'd1)
                begin
                    if (pos != POS_OPEN_A)
                        seq_flags.stays_open = 1'b1;
                    enter_end(req_cmd);
                end
                else
                begin
                    close_count = close_count - 8'd1;
                end
            end
            default:
            begin
                if (run && hold_count == 8'd0)
                begin
                    enter_idle(req_cmd);
                end
                else
                begin
                    if (hold_count != 8'd0)
                        hold_count = hold_count - 8'd1;
                    seq_cmd = req_cmd;
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        seq_result_t predicted;
        seq_result_t observed;
        seq_result_t wanted;
        if (!rst_n)
        begin
            cfg_open = OPEN_DELAY_RST;
            cfg_close = CLOSE_DELAY_RST;
            cfg_hold = END_HOLD_RST;
            cfg_code = TEST_CODE_RST;
            seq_phase = PH_IDLE;
            open_count = 8'd0;
            close_count = 8'd0;
            hold_count = 8'd0;
            seq_flags = '0;
            seq_cmd = 2'd0;
            expected_results.delete();
            fail_count = 0;
            results_checked = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_OPEN_DELAY:  cfg_open = pwdata[7:0];
                    REG_CLOSE_DELAY: cfg_close = pwdata[7:0];
                    REG_END_HOLD:    cfg_hold = pwdata[7:0];
                    default:         cfg_code = pwdata[7:0];
                endcase
            end

            if (in_valid && !in_stall)
            begin
                advance_sequencer(service_enable, action_code, flap_position,
                                  position_request);
                predicted = {seq_phase, seq_flags, seq_cmd};
                expected_results.push_back(predicted);
            end

            if (out_valid && !out_stall)
            begin
                observed = {test_phase, test_in_progress, actuator_active, test_complete,
                            blocked_open, flap_failed, stays_open, position_command};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no tick pending, expected none, got phase=%0d cmd=%0d",
                             $time, test_phase, position_command);
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    results_checked++;
                    if (observed !== wanted)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch (phase prog act done blk fail stay cmd)",
                                 $time);
                        $display("    expected %0d %b %b %b %b %b %b %0d", wanted.phase,
                                 wanted.flags.in_progress, wanted.flags.active,
                                 wanted.flags.complete, wanted.flags.blocked_open,
                                 wanted.flags.flap_failed, wanted.flags.stays_open,
                                 wanted.command);
                        $display("    actual   %0d %b %b %b %b %b %b %0d", observed.phase,
                                 observed.flags.in_progress, observed.flags.active,
                                 observed.flags.complete, observed.flags.blocked_open,
                                 observed.flags.flap_failed, observed.flags.stays_open,
                                 observed.command);
                    end
                end
            end

            outstanding <= expected_results.size();
        end
    end

endmodule

/* dv/tb_flap_actuator_test_sequencer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flap_actuator_test_sequencer - flap actuator test sequencer testbench
// Drives directed and random tick streams through several register settings
// with random sender gaps and receiver stalls; the checker scores results.
// ----------------------------------------------------------------------------
module tb_flap_actuator_test_sequencer;
    import fats_pkg::*;

    // Kinds of random tick segments
    typedef enum int {SEG_RUN, SEG_MIXED, SEG_NOISE} seg_kind_t;
    // Receiver stall patterns
    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BURSTY} flow_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        service_enable = 1'b0;
    logic [7:0]  action_code = 8'd0;
    logic [7:0]  flap_position = 8'd0;
    logic [7:0]  position_request = 8'd0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  test_phase;
    logic        test_in_progress;
    logic        actuator_active;
    logic        test_complete;
    logic        blocked_open;
    logic        flap_failed;
    logic        stays_open;
    logic [1:0]  position_command;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          outstanding;
    int          results_checked;

    int          burst_left = 0;
    int          ticks_sent = 0;
    int          settings_used = 0;
    logic [7:0]  code_setting = 8'd0;
    int          stall_left = 0;
    flow_kind_t  flow_kind = FLOW_FREE;

    always #6 clk = ~clk;

    flap_actuator_test_sequencer i_dut (.*);

    flap_sequencer_checker i_checker (.*);

    // Hard stop in case the block hangs or loses a result.
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: switch between free flow, light and heavy random stalls and a
    // regular bursty pattern each time a random-length run of the current one ends.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            flow_kind = flow_kind_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 80);
        end
        else
        begin
            stall_left = stall_left - 1;
        end
        case (flow_kind)
            FLOW_FREE:  out_stall <= 1'b0;
            FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
            default:    out_stall <= ((stall_left % 16) < 10);
        endcase
    end

    // Send one tick transaction; open a new burst after a random gap when the
    // current burst is used up. Hold the payload until the block takes it.
    task automatic send_tick(input logic svc, input logic [7:0] code,
                             input logic [7:0] pos, input logic [7:0] req);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        service_enable <= svc;
        action_code <= code;
        flap_position <= pos;
        position_request <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left = burst_left - 1;
        ticks_sent = ticks_sent + 1;
    endtask

    // Drop valid and wait until every predicted result has been taken, then
    // let the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB write: setup phase, then access phase, then an idle phase.
    // Upper data bits carry junk, only the low byte is a register value.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        logic [31:0] upper;
        upper = $urandom();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {upper[31:8], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all four registers once the block is quiet.
    task automatic program_settings(input logic [7:0] od, input logic [7:0] cd,
                                    input logic [7:0] eh, input logic [7:0] tc);
        drain_results();
        write_reg(REG_OPEN_DELAY, od);
        write_reg(REG_CLOSE_DELAY, cd);
        write_reg(REG_END_HOLD, eh);
        write_reg(REG_TEST_CODE, tc);
        code_setting = tc;
        settings_used = settings_used + 1;
    endtask

    // Random tick. Run segments mostly keep the test enabled with positions biased
    // toward the meaningful codes; mixed segments scramble enable and code, noise
    // segments scramble enable, code and position.
    task automatic random_tick(input seg_kind_t kind);
        logic       svc;
        logic [7:0] code;
        logic [7:0] pos;
        logic [7:0] req;
        int         r;
        r = $urandom_range(0, 15);
        if (r < 3)
            pos = POS_CLOSED;
        else if (r < 13)
        begin
            case ($urandom_range(0, 2))
                0:       pos = POS_OPEN_A;
                1:       pos = POS_BLOCKED;
                default: pos = POS_OPEN_B;
            endcase
        end
        else
            pos = 8'($urandom_range(0, 255));
        req = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
                                          : 8'($urandom_range(0, 255));
        case (kind)
            SEG_RUN:
            begin
                svc = 1'b1;
                code = code_setting;
                // now and then break the run: drop enable or use a wrong code
                if ($urandom_range(0, 39) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        svc = 1'b0;
                    else
                        code = code_setting ^ 8'($urandom_range(1, 255));
                end
            end
            SEG_MIXED:
            begin
                svc = 1'($urandom_range(0, 1));
                code = ($urandom_range(0, 1) == 1) ? code_setting : 8'($urandom_range(0, 255));
            end
            default:
            begin
                svc = 1'($urandom_range(0, 1));
                code = 8'($urandom_range(0, 255));
                pos = 8'($urandom_range(0, 255));
            end
        endcase
        send_tick(svc, code, pos, req);
    endtask

    initial
    begin
        int         ph;
        int         n;
        int         r;
        int         seg_left;
        seg_kind_t  seg_kind;
        logic [7:0] od;
        logic [7:0] cd;
        logic [7:0] eh;
        logic [7:0] tc;

        seg_left = 0;
        seg_kind = SEG_RUN;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with short countdowns: open 2, close 2, hold 1.
        program_settings(8'd2, 8'd2, 8'd1, 8'hA5);
        send_tick(1'b0, 8'hA5, POS_OPEN_A, 8'd255);     // idle, disabled: request clamps to 3
        send_tick(1'b1, 8'h5A, POS_OPEN_A, 8'd2);       // idle, wrong code
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // start
        send_tick(1'b1, 8'hA5, POS_CLOSED, 8'd1);       // closed seen: go closing
        send_tick(1'b1, 8'hA5, POS_CLOSED, 8'd0);       // close countdown
        send_tick(1'b1, 8'hA5, POS_CLOSED, 8'd2);       // close timeout, flap not open: stays open
        send_tick(1'b0, 8'hA5, POS_OPEN_A, 8'd1);       // end, disabled: hold counts down
        send_tick(1'b0, 8'hA5, POS_OPEN_A, 8'd128);     // end, disabled, hold done: stay in end
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd3);       // end, enabled: back to idle
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // start
        send_tick(1'b1, 8'hA5, 8'd4, 8'd0);             // open countdown, unknown position
        send_tick(1'b1, 8'hA5, 8'd255, 8'd7);           // open timeout, unknown position: wait
        send_tick(1'b1, 8'hA5, POS_BLOCKED, 8'd2);      // open timeout: blocked open
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd1);       // end hold counts down while enabled
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // back to idle
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // start
        send_tick(1'b0, 8'hA5, POS_OPEN_A, 8'd2);       // abort while opening
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // start
        send_tick(1'b1, 8'hA5, POS_OPEN_B, 8'd0);       // open countdown
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd3);       // open timeout: flap failed
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // end hold countdown
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // back to idle
        send_tick(1'b1, 8'hA5, POS_OPEN_A, 8'd0);       // start
        send_tick(1'b1, 8'hA5, POS_CLOSED, 8'd0);       // go closing
        send_tick(1'b1, 8'h25, POS_OPEN_A, 8'd1);       // abort while closing

        // Random phases: zero delays, all-ones, exactly at the limits, just
        // above them, then short random countdowns.
        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:
                begin
                    od = 8'd0;
                    cd = 8'd0;
                    eh = 8'd0;
                    tc = 8'h00;
                end
                1:
                begin
                    od = 8'd255;
                    cd = 8'd255;
                    eh = 8'd255;
                    tc = 8'hFF;
                end
                2:
                begin
                    od = OPEN_MAX;
                    cd = CLOSE_MAX;
                    eh = HOLD_MAX;
                    tc = 8'($urandom_range(0, 255));
                end
                3:
                begin
                    od = OPEN_MAX + 8'd1;
                    cd = CLOSE_MAX + 8'd1;
                    eh = HOLD_MAX + 8'd1;
                    tc = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    od = 8'($urandom_range(1, 8));
                    cd = 8'($urandom_range(1, 6));
                    eh = 8'($urandom_range(0, 5));
                    tc = 8'($urandom_range(0, 255));
                end
            endcase
            program_settings(od, cd, eh, tc);

            for (n = 0; n < 155; n++)
            begin
                // pause mid-phase until every pending result is back
                if (n == 77)
                    drain_results();
                if (seg_left == 0)
                begin
                    r = $urandom_range(0, 9);
                    seg_kind = (r < 7) ? SEG_RUN : ((r == 7) ? SEG_MIXED : SEG_NOISE);
                    seg_left = $urandom_range(5, 60);
                end
                random_tick(seg_kind);
                seg_left = seg_left - 1;
            end
        end

        drain_results();

        $display("Summary: %0d ticks under %0d register settings, %0d results compared",
                 ticks_sent, settings_used, results_checked);
        $display("Summary: directed phase walk, verdicts, aborts, clamped and zero delays");
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
